### sv/met_pkg.sv
package met_pkg;

  // Width of a point coordinate: 32-bit origin plus 10-bit index times 32-bit step.
  localparam int C_W = 43;

  localparam int MAX_COLS_DEF     = 1024;
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int PALETTE_SIZE_DEF = 8;
  localparam int FRAC_BITS_DEF    = 28;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [23:0] BACKGROUND = 24'hFFFFFF;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MIN_X      = 3'd0;
  localparam logic [2:0] REG_INC_X      = 3'd1;
  localparam logic [2:0] REG_MIN_Y      = 3'd2;
  localparam logic [2:0] REG_INC_Y      = 3'd3;
  localparam logic [2:0] REG_MAX_ITER   = 3'd4;
  localparam logic [2:0] REG_FILL_COLOR = 3'd5;
  localparam logic [2:0] REG_ESC_LIMIT  = 3'd6;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] inc_x;
    logic signed [31:0] min_y;
    logic signed [31:0] inc_y;
    logic [15:0]        max_iterations;
    logic [23:0]        fill_color;
    logic [6:0]         escape_limit_sq;
  } met_cfg_t;

  localparam met_cfg_t CFG_RESET = '{
    min_x:           32'shE0000000,
    inc_x:           32'sd1048576,
    min_y:           32'shE0000000,
    inc_y:           32'sd1048576,
    max_iterations:  16'd256,
    fill_color:      24'd0,
    escape_limit_sq: 7'd16
  };

  typedef struct packed {
    logic signed [C_W-1:0] cr;
    logic signed [C_W-1:0] ci;
    logic                  outside;
  } met_job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_UPD,
    S_FIN
  } met_state_t;

  function automatic logic [23:0] met_palette(input logic [3:0] idx);
    logic [23:0] color;
    unique case (idx[2:0])
      3'd0:    color = 24'h04182B;
      3'd1:    color = 24'h5A8C8C;
      3'd2:    color = 24'hF2D99D;
      3'd3:    color = 24'h738585;
      3'd4:    color = 24'hAB1111;
      3'd5:    color = 24'h04182B;
      3'd6:    color = 24'h5A8C8C;
      3'd7:    color = 24'hF2D99D;
      default: color = 24'h04182B;
    endcase
    return color;
  endfunction

endpackage

### sv/met_front.sv
module met_front #(
  parameter int MAX_COLS = met_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = met_pkg::MAX_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::met_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [9:0]        in_col,
  input  logic [9:0]        in_row,
  output logic              push_valid,
  input  logic              push_ready,
  output met_pkg::met_job_t push_job
);

  logic              valid_r, valid_nxt;
  met_pkg::met_job_t job_r;
  met_pkg::met_job_t job_nxt;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_job   = job_r;

  // Form the point exactly and flag pixels beyond the image.
  always_comb begin
    job_nxt.cr      = met_pkg::C_W'(cfg.min_x) +
                      met_pkg::C_W'($signed({1'b0, in_col})) * met_pkg::C_W'(cfg.inc_x);
    job_nxt.ci      = met_pkg::C_W'(cfg.min_y) +
                      met_pkg::C_W'($signed({1'b0, in_row})) * met_pkg::C_W'(cfg.inc_y);
    job_nxt.outside = (32'(in_col) >= MAX_COLS) || (32'(in_row) >= MAX_ROWS);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

### sv/met_queue.sv
module met_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = met_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

### sv/met_back.sv
module met_back #(
  parameter int FRAC_BITS    = met_pkg::FRAC_BITS_DEF,
  parameter int PALETTE_SIZE = met_pkg::PALETTE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::met_cfg_t cfg,
  input  logic              job_valid,
  output logic              job_ready,
  input  met_pkg::met_job_t job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic              out_tuser
);

  localparam int ZW  = FRAC_BITS + 5;
  localparam int PW  = 2 * ZW;
  localparam int SQW = FRAC_BITS + 10;
  localparam int XW  = FRAC_BITS + 11;
  localparam int ZSW = ((FRAC_BITS + 11 > met_pkg::C_W) ? FRAC_BITS + 11 : met_pkg::C_W) + 2;

  localparam logic signed [ZSW-1:0] BOUND =
    {{(ZSW - FRAC_BITS - 5){1'b0}}, 5'd16, {FRAC_BITS{1'b0}}};
  localparam logic signed [ZSW-1:0] NBOUND = -BOUND;

  met_pkg::met_state_t state_r, state_nxt;

  logic signed [ZSW-1:0]         zr_r, zi_r;
  logic signed [met_pkg::C_W-1:0] cr_r, ci_r;
  logic                          outside_r;
  logic [15:0]                   n_r;
  logic [3:0]                    nmod_r;
  logic signed [PW-1:0]          p_rr_r, p_ii_r, p_ri_r;

  logic        out_valid_r;
  logic [23:0] out_color_r;
  logic        out_write_r;
  logic [15:0] out_count_r;

  logic signed [ZW-1:0]  zr_op, zi_op;
  logic                  at_max, beyond_bound, escaped_mag;
  logic signed [SQW-1:0] sr_w, si_w, sum_w, lim_w;
  logic signed [XW-1:0]  cross_w;
  logic signed [ZSW-1:0] zr_upd, zi_upd;
  logic                  out_free, out_load;
  logic [23:0]           color_w;
  logic                  write_w;

  assign zr_op        = zr_r[ZW-1:0];
  assign zi_op        = zi_r[ZW-1:0];
  assign at_max       = (n_r == cfg.max_iterations);
  assign beyond_bound = (zr_r >= BOUND) || (zr_r <= NBOUND) ||
                        (zi_r >= BOUND) || (zi_r <= NBOUND);

  // Floor division by a power of two is the upper slice of the exact product.
  assign sr_w        = p_rr_r[FRAC_BITS+SQW-1:FRAC_BITS];
  assign si_w        = p_ii_r[FRAC_BITS+SQW-1:FRAC_BITS];
  assign cross_w     = p_ri_r[FRAC_BITS+XW-2:FRAC_BITS-1];
  assign sum_w       = sr_w + si_w;
  assign lim_w       = $signed({3'b000, cfg.escape_limit_sq, {FRAC_BITS{1'b0}}});
  assign escaped_mag = (sum_w >= lim_w);
  assign zr_upd      = ZSW'(sr_w) - ZSW'(si_w) + ZSW'(cr_r);
  assign zi_upd      = ZSW'(cross_w) + ZSW'(ci_r);

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_color_r};
  assign out_tuser  = out_write_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      met_pkg::S_IDLE: begin
        if (job_valid) begin
          state_nxt = job.outside ? met_pkg::S_FIN : met_pkg::S_CHK;
        end
      end
      met_pkg::S_CHK: begin
        state_nxt = (at_max || beyond_bound) ? met_pkg::S_FIN : met_pkg::S_UPD;
      end
      met_pkg::S_UPD: begin
        state_nxt = escaped_mag ? met_pkg::S_FIN : met_pkg::S_CHK;
      end
      met_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = met_pkg::S_IDLE;
        end
      end
      default: state_nxt = met_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state_r == met_pkg::S_IDLE);
    out_load  = (state_r == met_pkg::S_FIN) && out_free;
  end

  always_comb begin
    color_w = met_pkg::BACKGROUND;
    write_w = 1'b0;
    if (!outside_r) begin
      if (cfg.fill_color == 24'd0) begin
        color_w = met_pkg::met_palette(nmod_r);
        write_w = 1'b1;
      end else if (at_max) begin
        color_w = cfg.fill_color;
        write_w = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= met_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      met_pkg::S_IDLE: begin
        if (job_valid) begin
          zr_r      <= '0;
          zi_r      <= '0;
          cr_r      <= job.cr;
          ci_r      <= job.ci;
          outside_r <= job.outside;
          n_r       <= '0;
          nmod_r    <= '0;
        end
      end
      met_pkg::S_CHK: begin
        p_rr_r <= PW'(zr_op) * PW'(zr_op);
        p_ii_r <= PW'(zi_op) * PW'(zi_op);
        p_ri_r <= PW'(zr_op) * PW'(zi_op);
      end
      met_pkg::S_UPD: begin
        if (!escaped_mag) begin
          zr_r   <= zr_upd;
          zi_r   <= zi_upd;
          n_r    <= n_r + 16'd1;
          nmod_r <= (nmod_r == 4'(PALETTE_SIZE - 1)) ? 4'd0 : nmod_r + 4'd1;
        end
      end
      met_pkg::S_FIN: begin
        if (out_load) begin
          out_color_r <= color_w;
          out_write_r <= write_w;
          out_count_r <= n_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_upd_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == met_pkg::S_UPD) |-> ($past(state_r) == met_pkg::S_CHK))
    else $error("update step not preceded by multiply step");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != met_pkg::S_IDLE) |-> (5'(nmod_r) < 5'(PALETTE_SIZE)))
    else $error("palette counter out of range");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == met_pkg::S_FIN && outside_r) |-> (n_r == 16'd0))
    else $error("pixel outside image ran iterations");
`endif

endmodule

### sv/mandelbrot_escape_time_pixel_unit.sv
// Mandelbrot escape-time evaluator for one pixel per transaction. Send {row, col} on the
// input stream; the unit forms c = (min_x + col*inc_x, min_y + row*inc_y) in signed Q4.28,
// iterates z = z*z + c from zero and returns the iteration count together with a colour:
// in palette mode (fill_color zero) the colour comes from an eight-entry palette indexed by
// count mod PALETTE_SIZE; otherwise fill_color is given only for pixels that used all
// max_iterations steps, and every other pixel comes back white with write_pixel low.
// Iteration stops when |z|^2 reaches escape_limit_sq (whole units), when either component
// of z reaches +/-16, or when max_iterations steps are done. Each iteration runs through
// S_CHK (cap and bound checks, the three parallel squarings/cross product) and then S_UPD
// (escape compare and update); the result then waits in S_FIN until the output is free.
// Pixels outside the image skip the loop and go straight to S_FIN.
// A front stage computes c and a two-entry queue decouples it from the iteration loop, so
// the next pixels are taken while one is iterating or its result waits on the output.
// Write configuration registers only while no pixel is in flight.
module mandelbrot_escape_time_pixel_unit #(
  parameter int MAX_COLS     = met_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = met_pkg::MAX_ROWS_DEF,
  parameter int PALETTE_SIZE = met_pkg::PALETTE_SIZE_DEF,
  parameter int FRAC_BITS    = met_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [9:0] col, [19:10] row, [23:20] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [23:0] pixel_color, [39:24] iteration_count
  output logic        out_tuser,   // [0] write_pixel
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  met_pkg::met_cfg_t cfg_r;

  logic              fq_valid, fq_ready;
  met_pkg::met_job_t fq_job;
  logic              qb_valid, qb_ready;
  logic [$bits(met_pkg::met_job_t)-1:0] qb_data;
  met_pkg::met_job_t qb_job;

  // Register file: hold values, reload reset values on reset, drop writes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= met_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        met_pkg::REG_MIN_X:      cfg_r.min_x           <= $signed(cfg_wdata);
        met_pkg::REG_INC_X:      cfg_r.inc_x           <= $signed(cfg_wdata);
        met_pkg::REG_MIN_Y:      cfg_r.min_y           <= $signed(cfg_wdata);
        met_pkg::REG_INC_Y:      cfg_r.inc_y           <= $signed(cfg_wdata);
        met_pkg::REG_MAX_ITER:   cfg_r.max_iterations  <= cfg_wdata[15:0];
        met_pkg::REG_FILL_COLOR: cfg_r.fill_color      <= cfg_wdata[23:0];
        met_pkg::REG_ESC_LIMIT:  cfg_r.escape_limit_sq <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept a pixel, form its point, classify in or out of the image.
  met_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_col     (in_tdata[9:0]),
    .in_row     (in_tdata[19:10]),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job)
  );

  // Queue: let the front keep taking pixels while the loop iterates.
  met_queue #(
    .WIDTH ($bits(met_pkg::met_job_t)),
    .DEPTH (met_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  assign qb_job = qb_data;

  // Back: run the escape-time loop and register the result.
  met_back #(
    .FRAC_BITS    (FRAC_BITS),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .job        (qb_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/mandelbrot_pixel_checker.sv
`timescale 1ns / 1ps

module mandelbrot_pixel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,    // [9:0] col, [19:10] row, [23:20] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // [23:0] pixel_color, [39:24] iteration_count
  input  logic        out_tuser,   // [0] write_pixel
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          faults,
  output int          pending
);
  import met_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic [23:0] color;
    logic        write;
    logic [15:0] count;
  } pixel_result_t;

  pixel_result_t      pixel_q[$];
  logic signed [31:0] win_min_x, win_inc_x, win_min_y, win_inc_y;
  logic [15:0]        iter_cap;
  logic [23:0]        fill_rgb;
  logic [6:0]         escape_sq;

  initial begin
    faults  = 0;
    pending = 0;
  end

  task automatic note_fault(input string msg);
    if (faults < 40)
      $display("%0t mismatch: %s", $realtime, msg);
    faults++;
  endtask

  function automatic logic [23:0] shade(input logic [2:0] idx);
    logic [23:0] rgb;
    case (idx)
      3'd0, 3'd5: rgb = 24'h04182B;
      3'd1, 3'd6: rgb = 24'h5A8C8C;
      3'd2, 3'd7: rgb = 24'hF2D99D;
      3'd3:       rgb = 24'h738585;
      default:    rgb = 24'hAB1111;
    endcase
    return rgb;
  endfunction

  // Count square-and-add steps from z = 0 until escape or the iteration cap.
  function automatic logic [15:0] escape_steps(input longint cr, input longint ci);
    longint              zr, zi, sr, si, cross_term, bound, lim;
    logic signed [127:0] prod;
    int unsigned         n;
    bit                  done;
    bound = 64'sd16 <<< FRAC;
    lim   = longint'(escape_sq) <<< FRAC;
    zr    = 0;
    zi    = 0;
    n     = 0;
    done  = 1'b0;
    while (!done && n < iter_cap) begin
      if (zr >= bound || zr <= -bound || zi >= bound || zi <= -bound) begin
        done = 1'b1;
      end else begin
        // Arithmetic right shift of the full product floors toward minus infinity.
        prod = zr * zr;
        sr   = prod >>> FRAC;
        prod = zi * zi;
        si   = prod >>> FRAC;
        if (sr + si >= lim) begin
          done = 1'b1;
        end else begin
          prod       = zr * zi;
          cross_term = prod >>> (FRAC - 1);
          zr         = sr - si + cr;
          zi         = cross_term + ci;
          n++;
        end
      end
    end
    return n[15:0];
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [9:0] col, input logic [9:0] row);
    pixel_result_t r;
    longint        cr, ci;
    r.color = BACKGROUND;
    r.write = 1'b0;
    r.count = '0;
    if (col < MAX_COLS_DEF && row < MAX_ROWS_DEF) begin
      cr      = longint'(win_min_x) + longint'(col) * longint'(win_inc_x);
      ci      = longint'(win_min_y) + longint'(row) * longint'(win_inc_y);
      r.count = escape_steps(cr, ci);
      if (fill_rgb == '0) begin
        r.color = shade(3'(r.count % PALETTE_SIZE_DEF));
        r.write = 1'b1;
      end else if (r.count == iter_cap) begin
        r.color = fill_rgb;
        r.write = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pixel_result_t want;
    if (!rst_n) begin
      win_min_x = CFG_RESET.min_x;
      win_inc_x = CFG_RESET.inc_x;
      win_min_y = CFG_RESET.min_y;
      win_inc_y = CFG_RESET.inc_y;
      iter_cap  = CFG_RESET.max_iterations;
      fill_rgb  = CFG_RESET.fill_color;
      escape_sq = CFG_RESET.escape_limit_sq;
      pixel_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN_X:      win_min_x = cfg_wdata;
          REG_INC_X:      win_inc_x = cfg_wdata;
          REG_MIN_Y:      win_min_y = cfg_wdata;
          REG_INC_Y:      win_inc_y = cfg_wdata;
          REG_MAX_ITER:   iter_cap  = cfg_wdata[15:0];
          REG_FILL_COLOR: fill_rgb  = cfg_wdata[23:0];
          REG_ESC_LIMIT:  escape_sq = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          note_fault($sformatf("unexpected result tdata=%h tuser=%b", out_tdata, out_tuser));
        end else begin
          want = pixel_q.pop_front();
          if (out_tdata[23:0] !== want.color)
            note_fault($sformatf("pixel_color got %h want %h (count %0d)",
                                 out_tdata[23:0], want.color, want.count));
          if (out_tuser !== want.write)
            note_fault($sformatf("write_pixel got %b want %b (count %0d)",
                                 out_tuser, want.write, want.count));
          if (out_tdata[39:24] !== want.count)
            note_fault($sformatf("iteration_count got %0d want %0d",
                                 out_tdata[39:24], want.count));
        end
      end
      if (in_tvalid && in_tready)
        pixel_q.push_back(predict_pixel(in_tdata[9:0], in_tdata[19:10]));
    end
    pending = pixel_q.size();
  end

endmodule

### tb/tb_mandelbrot_escape_time_pixel_unit.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel_unit;
  import met_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;     // [9:0] col, [19:10] row, [23:20] zero
  logic        out_tready = 1'b1;
  logic        cfg_wr_en  = 1'b0;
  logic [2:0]  cfg_index  = REG_MIN_X;
  logic [31:0] cfg_wdata  = '0;

  wire         in_tready;
  wire         out_tvalid;
  wire  [39:0] out_tdata;           // [23:0] pixel_color, [39:24] iteration_count
  wire         out_tuser;           // [0] write_pixel

  int          faults;
  int          pending;
  int          sent       = 0;
  int          burst_left = 0;
  int          rx_span    = 0;
  int          rx_mode    = 0;
  int          rx_tick    = 0;

  // 2 ns clock period
  always #1 clk = ~clk;

  mandelbrot_escape_time_pixel_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mandelbrot_pixel_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .faults     (faults),
    .pending    (pending)
  );

  // Receiver back-pressure: switch between always ready, coin flips, sparse
  // ready and a periodic stall window, each held for a random stretch.
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(40, 300);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      0:       out_tready = 1'b1;
      1:       out_tready = 1'($urandom_range(0, 1));
      2:       out_tready = ($urandom_range(0, 4) == 0);
      default: out_tready = (rx_tick % 24) >= 10;
    endcase
  end

  // Offer one pixel and hold it until the transaction completes. The sender
  // runs in bursts; between bursts drop valid for a random gap (sometimes none).
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, row, col};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Drop valid and wait until every pixel in flight has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Reprogram the whole register file; only legal once the unit is idle.
  task automatic program_regs(input logic [31:0] mx, input logic [31:0] ix,
                              input logic [31:0] my, input logic [31:0] iy,
                              input logic [15:0] maxit, input logic [23:0] fill,
                              input logic [6:0] esc);
    settle();
    write_reg(REG_MIN_X, mx);
    write_reg(REG_INC_X, ix);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_INC_Y, iy);
    write_reg(REG_MAX_ITER, {16'd0, maxit});
    write_reg(REG_FILL_COLOR, {8'd0, fill});
    write_reg(REG_ESC_LIMIT, {25'd0, esc});
  endtask

  // One random phase: a register setting followed by a batch of pixels.
  task automatic random_phase();
    logic [31:0] mx, ix, my, iy;
    logic [15:0] maxit;
    logic [23:0] fill;
    logic [6:0]  esc;
    int          kind, n;
    kind  = $urandom_range(0, 11);
    // Default window: somewhere around the set so counts spread out.
    mx    = 32'hD8000000 + $urandom_range(0, 805306368);
    my    = 32'hE8000000 + $urandom_range(0, 268435456);
    ix    = $urandom_range(0, 1 << 20);
    iy    = $urandom_range(0, 1 << 20);
    if ($urandom_range(0, 5) == 0) ix = -ix;
    if ($urandom_range(0, 5) == 0) iy = -iy;
    maxit = 16'($urandom_range(1, 48));
    fill  = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(1, 24'hFFFFFF));
    esc   = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(1, 64));
    n     = $urandom_range(20, 70);
    case (kind)
      0, 1: begin
        // Raw register bits: random values for all bits of the window registers.
        mx = $urandom();
        ix = $urandom();
        my = $urandom();
        iy = $urandom();
      end
      2: begin
        // Longer orbits, fewer pixels to bound the run time.
        maxit = 16'($urandom_range(100, 400));
        n     = $urandom_range(5, 12);
      end
      3: begin
        // Near the top of the cap, window far out so every orbit leaves fast.
        maxit = 16'($urandom_range(16'hF000, 16'hFFFF));
        mx    = $urandom_range(32'h60000000, 32'h7FFFFFFF);
        ix    = $urandom_range(0, 1 << 16);
      end
      4: maxit = 16'($urandom_range(0, 3));
      default: ;
    endcase
    program_regs(mx, ix, my, iy, maxit, fill, esc);
    repeat (n)
      send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
  endtask

  initial begin : stimulus
    int waited;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset window: corners, the origin (in the set) and c = -1 (in the set).
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd256, 10'd512);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd700, 10'd600);

    // Register extremes: most negative/positive origins and steps, full cap,
    // all-ones fill and the largest escape limit.
    program_regs(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                 16'hFFFF, 24'hFFFFFF, 7'd127);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd1023);

    // No iterations allowed: count stays zero and fill mode writes every pixel.
    program_regs(32'hE0000000, 32'd1048576, 32'hE0000000, 32'd1048576,
                 16'd0, 24'h123456, 7'd16);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd3, 10'd900);

    // Zero escape limit: every pixel escapes before the first step.
    program_regs(32'hE0000000, 32'd1048576, 32'hE0000000, 32'd1048576,
                 16'd256, 24'd0, 7'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1000, 10'd20);

    // Fill mode: in-set pixels get the fill colour, escaped ones stay white.
    program_regs(32'hE0000000, 32'd1048576, 32'hE0000000, 32'd1048576,
                 16'd32, 24'hABCDEF, 7'd4);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd300, 10'd512);

    // Escape limit beyond the nominal range: the component bound must take over.
    program_regs(32'hE0000000, 32'd1048576, 32'hE0000000, 32'd1048576,
                 16'd20, 24'd0, 7'd100);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd900, 10'd900);
    send_pixel(10'd512, 10'd512);

    while (sent < 1350)
      random_phase();

    // Drain: bounded wait for the last results, then watch for strays.
    @(negedge clk);
    in_tvalid = 1'b0;
    waited    = 0;
    while (pending != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (pending != 0)
      $display("results never returned: %0d", pending);
    if (faults == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/met_pkg.sv
sv/met_front.sv
sv/met_queue.sv
sv/met_back.sv
sv/mandelbrot_escape_time_pixel_unit.sv
tb/mandelbrot_pixel_checker.sv
tb/tb_mandelbrot_escape_time_pixel_unit.sv
